// ----- design/voxel_occupancy_ray_query_unit_assert.svh -----
// ----------------------------------------------------------------------------
// voxel occupancy ray query unit - assertion macros
// shared concurrent assertion forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef VOXEL_OCCUPANCY_RAY_QUERY_UNIT_ASSERT_SVH
`define VOXEL_OCCUPANCY_RAY_QUERY_UNIT_ASSERT_SVH

// same-cycle implication
`define VOC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VOC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/voc_pkg.sv -----
// ----------------------------------------------------------------------------
// voc_pkg
// types and constants shared by the voxel occupancy ray query unit
// ----------------------------------------------------------------------------
package voc_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int MAX_STEPS   = 1024;

    localparam int ADDR_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int STEP_W  = $clog2(MAX_STEPS + 1);
    localparam int COORD_W = 16;
    localparam int KEY_W   = 3 * COORD_W;
    localparam int DIV_N_W = 31;
    localparam int DIV_D_W = 16;
    // crossing times grow by at most 2^30 per examined voxel
    localparam int T_W     = DIV_N_W + STEP_W;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_RAY    = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [23:0]        range_limit;
    } voc_req_t;

    typedef struct packed {
        logic             hit;
        logic             status;
        logic [CNT_W-1:0] entry_count;
    } voc_resp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] numer;
        logic [DIV_D_W-1:0] denom;
    } voc_div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quot;
    } voc_div_rsp_t;

endpackage

// ----- design/voc_ram.sv -----
// ----------------------------------------------------------------------------
// voc_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module voc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/voc_div.sv -----
// ----------------------------------------------------------------------------
// voc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module voc_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  voc_pkg::voc_div_req_t req,
    output voc_pkg::voc_div_rsp_t rsp
);

    localparam int CW = $clog2(voc_pkg::DIV_N_W + 1);

    logic [voc_pkg::DIV_D_W-1:0] rem_reg, rem_next;
    logic [voc_pkg::DIV_D_W-1:0] den_reg, den_next;
    logic [voc_pkg::DIV_N_W-1:0] quot_reg, quot_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [voc_pkg::DIV_D_W:0]   trial;
    logic [voc_pkg::DIV_D_W:0]   diff;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[voc_pkg::DIV_N_W-1]};
        diff      = trial - {1'b0, den_reg};
        if (req.start)
        begin
            rem_next  = '0;
            den_next  = req.denom;
            quot_next = req.numer;
            cnt_next  = CW'(voc_pkg::DIV_N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = diff[voc_pkg::DIV_D_W-1:0];
                quot_next = {quot_reg[voc_pkg::DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[voc_pkg::DIV_D_W-1:0];
                quot_next = {quot_reg[voc_pkg::DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ----- design/voxel_occupancy_ray_query_unit.sv -----
// ----------------------------------------------------------------------------
// voxel_occupancy_ray_query_unit
// occupied voxel key store with insert, point query, 3d dda ray query, clear
// ----------------------------------------------------------------------------
//  channel   signals                        direction
//  in        in_valid/in_ready/in_data      request in
//  out       out_valid/out_ready/out_data   result out
//  cfg       cfg_valid/cfg_ready/cfg_data   capacity register write
//
//  one request at a time; a store search reads one key per cycle from the ram.
//  ray: up to 6 divisions on the shared divider, then per voxel a lookup and a
//  step to the next boundary crossing, at most 1024 voxels.
//  reset empties the store at once (fill count) and sets capacity to 256.
//  a finished result waits in the output register while the next request
//  is taken; cfg is always ready.
// ----------------------------------------------------------------------------
`include "voxel_occupancy_ray_query_unit_assert.svh"

module voxel_occupancy_ray_query_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  voc_pkg::voc_req_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output voc_pkg::voc_resp_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [8:0]         cfg_data
);

    localparam int TW = voc_pkg::T_W;
    localparam int CW = voc_pkg::CNT_W;
    localparam int SW = voc_pkg::STEP_W;
    localparam int KW = voc_pkg::KEY_W;
    localparam int QW = voc_pkg::COORD_W;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_SCAN       = 3'd1;
    localparam logic [2:0] S_DIV_START  = 3'd2;
    localparam logic [2:0] S_DIV_WAIT   = 3'd3;
    localparam logic [2:0] S_WALK_CHECK = 3'd4;
    localparam logic [2:0] S_WALK_STEP  = 3'd5;
    localparam logic [2:0] S_FIN        = 3'd6;

    logic [2:0]         state_reg, state_next;
    voc_pkg::voc_req_t  req_reg, req_next;
    logic [KW-1:0]      key_reg, key_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [8:0]         max_entries_reg;
    logic [CW-1:0]      scan_idx_reg, scan_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic               hit_reg, hit_next;
    logic               status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    voc_pkg::voc_resp_t out_reg, out_next;
    logic [1:0]         axis_reg, axis_next;
    logic               phase_reg, phase_next;
    logic [TW-1:0]      t_reg, t_next;
    logic [SW-1:0]      examined_reg, examined_next;
    logic [TW-1:0]      tn_reg [3];
    logic [TW-1:0]      tn_next [3];
    logic [TW-1:0]      td_reg [3];
    logic [TW-1:0]      td_next [3];
    logic [QW-1:0]      c_reg [3];
    logic [QW-1:0]      c_next [3];
    logic [2:0]         live_reg, live_next;
    logic [2:0]         neg_reg, neg_next;

    logic                     ram_we;
    logic [voc_pkg::ADDR_W-1:0] ram_waddr;
    logic [KW-1:0]            ram_rdata;
    logic [CW-1:0]            cap;
    voc_pkg::voc_div_req_t    div_req;
    voc_pkg::voc_div_rsp_t    div_rsp;
    logic [23:0]              pos_sel;
    logic [15:0]              dir_sel;
    logic [15:0]              mag;
    logic [8:0]               gap_len;
    logic [TW-1:0]            range;
    logic                     found;
    logic                     req_fire;
    logic                     clear_fire;

    assign cap = (max_entries_reg > CW'(voc_pkg::MAX_ENTRIES)) ?
                 CW'(voc_pkg::MAX_ENTRIES) : CW'(max_entries_reg);
    assign range = TW'({req_reg.range_limit, 8'h00});
    assign found = cmp_valid_reg && (ram_rdata == key_reg);

    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                pos_sel = req_reg.pos_x;
                dir_sel = req_reg.dir_x;
            end
            2'd1:
            begin
                pos_sel = req_reg.pos_y;
                dir_sel = req_reg.dir_y;
            end
            default:
            begin
                pos_sel = req_reg.pos_z;
                dir_sel = req_reg.dir_z;
            end
        endcase
        // magnitude; the most negative code maps to 32768
        mag     = dir_sel[15] ? (~dir_sel + 16'd1) : dir_sel;
        gap_len = dir_sel[15] ? {1'b0, pos_sel[7:0]} : (9'd256 - {1'b0, pos_sel[7:0]});
    end

    always_comb
    begin
        logic          have;
        logic [1:0]    pick;
        logic [TW-1:0] best;

        state_next     = state_reg;
        req_next       = req_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = 1'b0;
        hit_next       = hit_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        axis_next      = axis_reg;
        phase_next     = phase_reg;
        t_next         = t_reg;
        examined_next  = examined_reg;
        tn_next        = tn_reg;
        td_next        = td_reg;
        c_next         = c_reg;
        live_next      = live_reg;
        neg_next       = neg_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[voc_pkg::ADDR_W-1:0];
        div_req.start  = 1'b0;
        div_req.denom  = mag;
        div_req.numer  = phase_reg ? (voc_pkg::DIV_N_W'(1) << 30) : {gap_len, 22'b0};
        have = 1'b0;
        pick = 2'd0;
        best = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next      = in_data;
                    key_next      = {in_data.pos_z[23:8], in_data.pos_y[23:8],
                                     in_data.pos_x[23:8]};
                    scan_idx_next = '0;
                    hit_next      = 1'b0;
                    status_next   = 1'b0;
                    case (in_data.operation)
                        voc_pkg::OP_INSERT, voc_pkg::OP_QUERY:
                            state_next = S_SCAN;
                        voc_pkg::OP_RAY:
                        begin
                            if (count_reg == '0 || in_data.range_limit == '0)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                axis_next     = 2'd0;
                                phase_next    = 1'b0;
                                t_next        = '0;
                                examined_next = '0;
                                live_next     = '0;
                                c_next[0]     = in_data.pos_x[23:8];
                                c_next[1]     = in_data.pos_y[23:8];
                                c_next[2]     = in_data.pos_z[23:8];
                                state_next    = S_DIV_START;
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (found)
                begin
                    // duplicate insert leaves the store as it is
                    hit_next   = (req_reg.operation != voc_pkg::OP_INSERT);
                    state_next = S_FIN;
                end
                else if (scan_idx_reg < count_reg)
                begin
                    scan_idx_next  = scan_idx_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                end
                else
                begin
                    case (req_reg.operation)
                        voc_pkg::OP_INSERT:
                        begin
                            if (count_reg >= cap)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            state_next = S_FIN;
                        end
                        voc_pkg::OP_RAY:
                            state_next = S_WALK_STEP;
                        default:
                            state_next = S_FIN;
                    endcase
                end
            end
            S_DIV_START:
            begin
                if (dir_sel == '0)
                begin
                    phase_next = 1'b0;
                    if (axis_reg == 2'd2)
                    begin
                        state_next = S_WALK_CHECK;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
                else
                begin
                    div_req.start      = 1'b1;
                    neg_next[axis_reg] = dir_sel[15];
                    state_next         = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (!phase_reg)
                    begin
                        tn_next[axis_reg] = TW'(div_rsp.quot);
                        phase_next        = 1'b1;
                        state_next        = S_DIV_START;
                    end
                    else
                    begin
                        td_next[axis_reg]   = TW'(div_rsp.quot);
                        live_next[axis_reg] = 1'b1;
                        phase_next          = 1'b0;
                        if (axis_reg == 2'd2)
                        begin
                            state_next = S_WALK_CHECK;
                        end
                        else
                        begin
                            axis_next  = axis_reg + 2'd1;
                            state_next = S_DIV_START;
                        end
                    end
                end
            end
            S_WALK_CHECK:
            begin
                if (t_reg >= range || examined_reg >= SW'(voc_pkg::MAX_STEPS))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    examined_next = examined_reg + SW'(1);
                    key_next      = {c_reg[2], c_reg[1], c_reg[0]};
                    scan_idx_next = '0;
                    state_next    = S_SCAN;
                end
            end
            S_WALK_STEP:
            begin
                // earliest boundary crossing, ties to the lower axis
                for (int a = 0; a < 3; a++)
                begin
                    if (live_reg[a] && (!have || tn_reg[a] < best))
                    begin
                        have = 1'b1;
                        pick = 2'(a);
                        best = tn_reg[a];
                    end
                end
                if (!have)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    t_next        = best;
                    tn_next[pick] = best + td_reg[pick];
                    c_next[pick]  = neg_reg[pick] ? (c_reg[pick] - QW'(1)) :
                                                    (c_reg[pick] + QW'(1));
                    state_next    = S_WALK_CHECK;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.hit         = hit_reg;
                    out_next.status      = status_reg;
                    out_next.entry_count = count_reg;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            max_entries_reg <= 9'd256;
            out_valid_reg   <= 1'b0;
            cmp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            cmp_valid_reg <= cmp_valid_next;
            if (cfg_valid)
            begin
                max_entries_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        key_reg      <= key_next;
        scan_idx_reg <= scan_idx_next;
        hit_reg      <= hit_next;
        status_reg   <= status_next;
        out_reg      <= out_next;
        axis_reg     <= axis_next;
        phase_reg    <= phase_next;
        t_reg        <= t_next;
        examined_reg <= examined_next;
        tn_reg       <= tn_next;
        td_reg       <= td_next;
        c_reg        <= c_next;
        live_reg     <= live_next;
        neg_reg      <= neg_next;
    end

    voc_ram #(
        .WIDTH (KW),
        .DEPTH (voc_pkg::MAX_ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .raddr (scan_idx_reg[voc_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    voc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    assign req_fire   = in_valid && in_ready;
    assign clear_fire = req_fire && (in_data.operation == voc_pkg::OP_CLEAR);

    `VOC_ASSERT_IMP(a_write_within_cap, ram_we, count_reg < cap, "key written past capacity")
    `VOC_ASSERT_NXT(a_clear_empties, clear_fire, count_reg == '0, "clear left keys")
    `VOC_ASSERT_NXT(a_busy_after_accept, req_fire, !in_ready, "ready right after request")
    `VOC_ASSERT_IMP(a_div_idle_on_start, div_req.start, !div_rsp.busy, "divider restarted")

endmodule
